// File: sv/ppae_pkg.sv
// shared types, constants and helper functions for the pixel access engine
`timescale 1ns / 1ps
package ppae_pkg;

   localparam int FRAME_BYTES     = 262144;
   localparam int PALETTE_ENTRIES = 256;
   localparam int FADDR_W         = $clog2(FRAME_BYTES);
   localparam int FWORD_ADDR_W    = FADDR_W - 2;
   localparam int FWORDS          = FRAME_BYTES / 4;
   localparam int PAL_ADDR_W      = $clog2(PALETTE_ENTRIES);

   localparam logic [31:0] MASK_R555 = 32'h0000_7C00;
   localparam logic [31:0] MASK_G555 = 32'h0000_03E0;
   localparam logic [31:0] MASK_B555 = 32'h0000_001F;

   typedef enum logic [2:0] {
      OP_GET_PIXEL = 3'd0,
      OP_SET_PIXEL = 3'd1,
      OP_GET_COLOR = 3'd2,
      OP_SET_COLOR = 3'd3,
      OP_WR_PAL    = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      REG_WIDTH  = 3'd0,
      REG_HEIGHT = 3'd1,
      REG_DEPTH  = 3'd2,
      REG_BOTUP  = 3'd3,
      REG_BITFLD = 3'd4,
      REG_RMASK  = 3'd5,
      REG_GMASK  = 3'd6,
      REG_BMASK  = 3'd7
   } reg_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_RANGE   = 2'd1,
      ST_REFUSED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      P_IDLE, P_LOC, P_RD0, P_RD1, P_PAL, P_WB0, P_WB1, P_OUT
   } phase_type;

   typedef struct packed {
      logic [10:0] width;
      logic [10:0] height;
      logic [2:0]  depth;
      logic        bottom_up;
      logic        bitfields;
      logic [31:0] rmask;
      logic [31:0] gmask;
      logic [31:0] bmask;
   } cfg_type;

   // shift and run length of a color mask
   typedef struct packed {
      logic [4:0] shift;
      logic [5:0] run;
   } mshape_type;

   function automatic logic [5:0] bpp_of(input logic [2:0] code);
      logic [5:0] r;
      case (code)
         3'd0: r = 6'd1;
         3'd1: r = 6'd4;
         3'd2: r = 6'd8;
         3'd3: r = 6'd16;
         3'd4: r = 6'd24;
         3'd5: r = 6'd32;
         default: r = 6'd0;
      endcase
      return r;
   endfunction

   function automatic mshape_type mask_shape(input logic [31:0] m);
      mshape_type r;
      logic [31:0] sh;
      logic [31:0] inv;
      r.shift = 5'd0;
      r.run = 6'd8;
      if (m != 32'd0) begin
         for (int i = 31; i >= 0; i--) begin
            if (m[i]) r.shift = 5'(i);
         end
         sh = m >> r.shift;
         inv = ~sh;
         r.run = 6'd32;
         for (int i = 31; i >= 0; i--) begin
            if (inv[i]) r.run = 6'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] decode(input logic [31:0] m, input mshape_type s,
                                         input logic [31:0] pix);
      logic [31:0] v;
      v = (m & pix) >> s.shift;
      if (s.run <= 6'd8) v = v << (6'd8 - s.run);
      else v = v >> (s.run - 6'd8);
      return v[7:0];
   endfunction

   function automatic logic [31:0] encode(input logic [31:0] m, input mshape_type s,
                                          input logic [7:0] c);
      logic [63:0] v;
      v = {56'd0, c};
      if (s.run <= 6'd8) v = v >> (6'd8 - s.run);
      else v = v << (s.run - 6'd8);
      v = v << s.shift;
      return v[31:0] & m;
   endfunction

endpackage

// File: sv/ppae_ram.sv
// generic single-port ram with byte enables and registered read
`timescale 1ns / 1ps
module ppae_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [WIDTH/8-1:0]       wr_be,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int i = 0; i < WIDTH / 8; i++) begin
            if (wr_be[i]) mem[addr][8*i +: 8] <= wr_data[8*i +: 8];
         end
      end
      rd_data <= mem[addr];
   end
endmodule

// File: sv/ppae_clear.sv
// post-reset clearing sweep over frame store and palette
`timescale 1ns / 1ps
module ppae_clear (
   input  logic                                clock,
   input  logic                                reset,
   output logic                                busy,
   output logic [ppae_pkg::FWORD_ADDR_W-1:0]   addr
);
   import ppae_pkg::*;
   logic [FWORD_ADDR_W:0] cnt_ff, cnt_in;

   always_comb begin
      cnt_in = cnt_ff;
      if (busy) cnt_in = cnt_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end

   assign busy = (cnt_ff < (FWORD_ADDR_W+1)'(FWORDS));
   assign addr = cnt_ff[FWORD_ADDR_W-1:0];
endmodule

// File: sv/ppae_addr.sv
// pixel locate: range check and byte address of a pixel
`timescale 1ns / 1ps
module ppae_addr (
   input  logic                     clock,
   input  ppae_pkg::cfg_type        cfg,
   input  logic                     load,
   input  logic [11:0]              pos_x,
   input  logic [11:0]              pos_y,
   output logic                     bad,
   output logic [ppae_pkg::FADDR_W-1:0] byte_addr
);
   import ppae_pkg::*;
   logic [5:0]  bpp;
   logic [15:0] row_bits;
   logic [12:0] pitch;
   logic [11:0] row;
   logic [25:0] a_full;
   logic [26:0] a_end;
   logic [2:0]  nbytes;
   logic        bad_in, bad_ff;
   logic [FADDR_W-1:0] a_ff;

   always_comb begin
      bpp = bpp_of(cfg.depth);
      row_bits = 16'(cfg.width) * 16'(bpp) + 16'd31;
      pitch = {row_bits[15:5], 2'b00};
      row = cfg.bottom_up ? 12'(cfg.height - 11'd1 - 11'(pos_y)) : pos_y;
      a_full = 26'(row) * 26'(pitch) + 26'((18'(pos_x) * 18'(bpp)) >> 3);
      nbytes = (bpp >= 6'd8) ? bpp[5:3] : 3'd1;
      a_end = 27'(a_full) + 27'(nbytes);
      bad_in = (cfg.depth > 3'd5) || (pos_x >= 12'(cfg.width)) ||
               (pos_y >= 12'(cfg.height)) || (a_end > 27'(FRAME_BYTES));
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bad_ff <= bad_in;
         a_ff <= a_full[FADDR_W-1:0];
      end
   end

   assign bad = bad_ff;
   assign byte_addr = a_ff;
endmodule

// File: sv/packed_pixel_access_engine.sv
// top level of the packed pixel access engine
// Usage: configure over the csr_ port while idle (csr_wr_en, csr_index, csr_wdata).
// Requests arrive on req_valid/req_stall; each beat carries one operation and
// yields one response beat on rsp_valid/rsp_stall.
// The frame store is a 32-bit word memory with byte lanes, read then written
// back; a pixel that crosses a word boundary (only at 24 bpp) takes a second word.
// Each item passes through locate, two word reads, a palette read, write-back (a
// second write-back when the pixel crosses a word), then the response register.
// One item is in flight at a time; req_stall is high until the response beat
// is taken, so a new item is taken only after the last one's response beat.
// After reset a clearing sweep zeroes the frame store, one word a cycle, over all
// FRAME_BYTES/4 (65536) words; the palette is cleared by the same sweep through
// its low address bits. Requests are stalled during the sweep; csr writes are taken.
// When rsp_stall is high the response holds and no new request is taken.
`timescale 1ns / 1ps
module packed_pixel_access_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [11:0] req_pos_x,
   input  logic [11:0] req_pos_y,
   input  logic [31:0] req_pixel_in,
   input  logic [7:0]  req_palette_slot,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic [7:0]  req_spare_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pixel_out,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic [7:0]  rsp_spare_out,
   output logic [1:0]  rsp_status
);
   import ppae_pkg::*;

   cfg_type cfg_ff;
   phase_type ph_ff, ph_in;

   logic [2:0]  op_ff;
   logic [11:0] x_ff;
   logic [31:0] pin_ff;
   logic [7:0]  slot_ff, r_ff, g_ff, b_ff, sp_ff;
   logic [31:0] w0_ff;
   logic [31:0] pix_ff, pix_in;
   logic [7:0]  ro_ff, go_ff, bo_ff, so_ff;
   logic [7:0]  ro_in, go_in, bo_in, so_in;
   logic [31:0] pixo_in;
   logic [1:0]  sto_in;
   logic [1:0]  st_ff;
   logic        do_wr_ff;

   logic clr_busy;
   logic [FWORD_ADDR_W-1:0] clr_addr;
   logic bad;
   logic [FADDR_W-1:0] baddr;

   ppae_clear u_clear (.clock, .reset, .busy(clr_busy), .addr(clr_addr));

   ppae_addr u_addr (
      .clock, .cfg(cfg_ff), .load(ph_ff == P_IDLE), .pos_x(req_pos_x),
      .pos_y(req_pos_y), .bad, .byte_addr(baddr)
   );

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{width: 11'd1, height: 11'd1, depth: 3'd2, bottom_up: 1'b1,
                     bitfields: 1'b0, rmask: '0, gmask: '0, bmask: '0};
      end else if (csr_wr_en) begin
         case (reg_type'(csr_index))
            REG_WIDTH:  cfg_ff.width <= csr_wdata[10:0];
            REG_HEIGHT: cfg_ff.height <= csr_wdata[10:0];
            REG_DEPTH:  cfg_ff.depth <= csr_wdata[2:0];
            REG_BOTUP:  cfg_ff.bottom_up <= csr_wdata[0];
            REG_BITFLD: cfg_ff.bitfields <= csr_wdata[0];
            REG_RMASK:  cfg_ff.rmask <= csr_wdata;
            REG_GMASK:  cfg_ff.gmask <= csr_wdata;
            REG_BMASK:  cfg_ff.bmask <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic accept;
   assign req_stall = (ph_ff != P_IDLE) || clr_busy;
   assign accept = req_valid && !req_stall;

   // derived per-op values
   logic [5:0] bpp;
   logic [1:0] lane;
   logic [FWORD_ADDR_W-1:0] waddr0, waddr1;
   logic two_words;
   logic [63:0] pair;
   logic [31:0] raw;
   logic [63:0] wr_pair, wr_mask;
   logic [2:0]  bit_sh;
   logic [2:0]  nbytes;
   logic is_pix_op;
   logic [31:0] m0, m1, m2;
   logic use_m;
   mshape_type s0, s1, s2;
   logic do_wr_in;
   logic [1:0] st_in;

   always_comb begin
      bpp = bpp_of(cfg_ff.depth);
      lane = baddr[1:0];
      waddr0 = baddr[FADDR_W-1:2];
      waddr1 = waddr0 + 1'b1;
      nbytes = (bpp >= 6'd8) ? bpp[5:3] : 3'd1;
      two_words = (3'(lane) + nbytes) > 3'd4;
      // word 1 is on the read port during the palette phase
      pair = {f_rd, w0_ff} >> {lane, 3'b000};
      bit_sh = (bpp == 6'd1) ? 3'd7 - x_ff[2:0] : (x_ff[0] ? 3'd0 : 3'd4);
      case (bpp)
         6'd1:  raw = 32'(pair[7:0] >> bit_sh) & 32'h1;
         6'd4:  raw = 32'(pair[7:0] >> bit_sh) & 32'hF;
         6'd8:  raw = {24'd0, pair[7:0]};
         6'd16: raw = {16'd0, pair[15:0]};
         6'd24: raw = {8'd0, pair[23:0]};
         default: raw = pair[31:0];
      endcase
      is_pix_op = (op_ff <= 3'd3);
      use_m = (cfg_ff.bitfields && (bpp == 6'd16 || bpp == 6'd32)) || bpp == 6'd16;
      if (cfg_ff.bitfields && (bpp == 6'd16 || bpp == 6'd32)) begin
         m0 = cfg_ff.rmask; m1 = cfg_ff.gmask; m2 = cfg_ff.bmask;
      end else begin
         m0 = MASK_R555; m1 = MASK_G555; m2 = MASK_B555;
      end
      s0 = mask_shape(m0); s1 = mask_shape(m1); s2 = mask_shape(m2);
   end

   // new pixel value for writes, computed once the words are read
   always_comb begin
      logic [31:0] v;
      logic [7:0]  nib;
      v = '0;
      nib = '0;
      if (op_ff == OP_SET_COLOR) begin
         if (use_m) v = encode(m0, s0, r_ff) | encode(m1, s1, g_ff) | encode(m2, s2, b_ff);
         else v = {(bpp == 6'd32) ? sp_ff : 8'd0, r_ff, g_ff, b_ff};
      end else begin
         v = pin_ff;
      end
      // merged write data as a 64-bit window aligned at lane
      wr_pair = '0;
      wr_mask = '0;
      case (bpp)
         6'd1: begin
            nib = (pair[7:0] & ~(8'h1 << bit_sh)) | ((v[7:0] & 8'h1) << bit_sh);
            wr_pair = {56'd0, nib};
            wr_mask = 64'hFF;
         end
         6'd4: begin
            nib = (pair[7:0] & ~(8'hF << bit_sh)) | ((v[7:0] & 8'hF) << bit_sh);
            wr_pair = {56'd0, nib};
            wr_mask = 64'hFF;
         end
         6'd8:  begin wr_pair = {56'd0, v[7:0]};  wr_mask = 64'hFF; end
         6'd16: begin wr_pair = {48'd0, v[15:0]}; wr_mask = 64'hFFFF; end
         6'd24: begin wr_pair = {40'd0, v[23:0]}; wr_mask = 64'hFF_FFFF; end
         default: begin wr_pair = {32'd0, v}; wr_mask = 64'hFFFF_FFFF; end
      endcase
      wr_pair = wr_pair << {lane, 3'b000};
      wr_mask = wr_mask << {lane, 3'b000};
      do_wr_in = 1'b0;
      st_in = ST_OK;
      pix_in = '0;
      if (is_pix_op) begin
         case (op_type'(op_ff))
            OP_GET_PIXEL: begin
               if (bad) st_in = ST_RANGE; else pix_in = raw;
            end
            OP_SET_PIXEL: begin
               if (bad) st_in = ST_RANGE; else do_wr_in = 1'b1;
            end
            OP_GET_COLOR: begin
               if (bpp == 6'd0 || bad) st_in = ST_RANGE;
               if (!bad) pix_in = raw;
            end
            default: begin
               if (bpp == 6'd0) st_in = ST_RANGE;
               else if (bpp <= 6'd8) st_in = ST_REFUSED;
               else if (bad) st_in = ST_RANGE;
               else do_wr_in = 1'b1;
            end
         endcase
      end
   end

   // memory ports
   logic                    f_en;
   logic [3:0]              f_be;
   logic [FWORD_ADDR_W-1:0] f_addr;
   logic [31:0]             f_wd, f_rd;
   logic                    p_en;
   logic [PAL_ADDR_W-1:0]   p_addr;
   logic [31:0]             p_wd, p_rd;

   logic [63:0] wp_ff, wm_ff;
   logic [3:0]  be0, be1;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         be0[i] = wm_ff[8*i];
         be1[i] = wm_ff[32 + 8*i];
      end
      f_en = 1'b0; f_be = 4'hF; f_addr = waddr0; f_wd = '0;
      p_en = 1'b0; p_addr = slot_ff; p_wd = {sp_ff, r_ff, g_ff, b_ff};
      if (clr_busy) begin
         f_en = 1'b1; f_addr = clr_addr;
         p_en = 1'b1; p_addr = clr_addr[PAL_ADDR_W-1:0];
         p_wd = '0;
      end else begin
         case (ph_ff)
            P_RD1: f_addr = waddr1;
            // palette index straight from the pixel just read, zero when out of range
            P_PAL: p_addr = pix_in[PAL_ADDR_W-1:0];
            P_WB0: begin
               f_en = do_wr_ff; f_be = be0; f_wd = wp_ff[31:0];
               p_en = (op_ff == OP_WR_PAL);
            end
            P_WB1: begin
               f_en = do_wr_ff; f_addr = waddr1; f_be = be1; f_wd = wp_ff[63:32];
            end
            default: ;
         endcase
      end
   end

   ppae_ram #(.WIDTH(32), .DEPTH(FWORDS)) u_frame (
      .clock, .wr_en(f_en), .wr_be(f_be), .addr(f_addr), .wr_data(f_wd), .rd_data(f_rd)
   );

   ppae_ram #(.WIDTH(32), .DEPTH(PALETTE_ENTRIES)) u_pal (
      .clock, .wr_en(p_en), .wr_be(4'hF), .addr(p_addr), .wr_data(p_wd), .rd_data(p_rd)
   );

   // next phase
   always_comb begin
      ph_in = ph_ff;
      case (ph_ff)
         P_IDLE: if (accept) ph_in = P_LOC;
         P_LOC:  ph_in = P_RD0;
         P_RD0:  ph_in = P_RD1;
         P_RD1:  ph_in = P_PAL;
         P_PAL:  ph_in = P_WB0;
         P_WB0:  ph_in = two_words ? P_WB1 : P_OUT;
         P_WB1:  ph_in = P_OUT;
         P_OUT:  if (!rsp_stall) ph_in = P_IDLE;
         default: ph_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) ph_ff <= P_IDLE;
      else ph_ff <= ph_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_op; x_ff <= req_pos_x;
         pin_ff <= req_pixel_in; slot_ff <= req_palette_slot;
         r_ff <= req_red_in; g_ff <= req_green_in; b_ff <= req_blue_in;
         sp_ff <= req_spare_in;
      end
      // word 0 arrives in RD1, word 1 in PAL
      if (ph_ff == P_RD1) begin
         w0_ff <= f_rd;
      end
      if (ph_ff == P_PAL) begin
         pix_ff <= pix_in;
         st_ff <= st_in;
         do_wr_ff <= do_wr_in;
         wp_ff <= wr_pair | ({f_rd, w0_ff} & ~wr_mask);
         wm_ff <= wr_mask;
      end
   end

   // response fields, palette word is valid in WB0
   always_comb begin
      ro_in = '0; go_in = '0; bo_in = '0; so_in = '0;
      pixo_in = pix_ff;
      sto_in = st_ff;
      if (op_ff == OP_WR_PAL) begin
         pixo_in = '0;
         sto_in = ST_OK;
      end else if (op_ff == OP_GET_COLOR && bpp != 6'd0) begin
         if (bpp <= 6'd8) begin
            bo_in = p_rd[7:0]; go_in = p_rd[15:8];
            ro_in = p_rd[23:16]; so_in = p_rd[31:24];
         end else if (use_m) begin
            ro_in = decode(m0, s0, pix_ff);
            go_in = decode(m1, s1, pix_ff);
            bo_in = decode(m2, s2, pix_ff);
         end else begin
            bo_in = pix_ff[7:0]; go_in = pix_ff[15:8]; ro_in = pix_ff[23:16];
            so_in = (bpp == 6'd32) ? pix_ff[31:24] : 8'd0;
         end
      end else if (op_ff > 3'd4) begin
         pixo_in = '0;
         sto_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (ph_ff == P_WB0) begin
         ro_ff <= ro_in; go_ff <= go_in; bo_ff <= bo_in; so_ff <= so_in;
         rsp_pixel_out <= pixo_in;
         rsp_status <= sto_in;
      end
   end

   assign rsp_valid = (ph_ff == P_OUT);
   assign rsp_red_out = ro_ff;
   assign rsp_green_out = go_ff;
   assign rsp_blue_out = bo_ff;
   assign rsp_spare_out = so_ff;
endmodule
